// File: sv/plfs_pkg.sv
// ============================================================================
// plfs_pkg - shared types and constants for the point light shader
// Field widths, register indexes and the data that moves down the cell rows.
// ============================================================================
package plfs_pkg;

    localparam int COORD_W   = 16;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int SQ_W      = 2 * DIFF_W;
    localparam int D2_W      = SQ_W;
    localparam int ROOT_W    = D2_W / 2;
    localparam int REM_W     = ROOT_W + 3;
    localparam int RAD_W     = 16;
    localparam int DIV_W     = RAD_W + 1;
    localparam int RAMP_W    = 9;
    localparam int INT_W     = 9;
    localparam int STR_W     = INT_W + RAMP_W - 1;
    localparam int CHAN_W    = 8;
    localparam int COLOR_W   = 32;
    localparam int SQRT_STEPS_DEF = ROOT_W;
    localparam int DIV_STEPS_DEF  = RAMP_W;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    localparam logic [INT_W-1:0]  UNITY    = INT_W'(256);
    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;

    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FALL_IN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FALL_OUT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_RED = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_GRN = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_BLU = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_INTENSITY = 3'd7;

    // per-item data that rides along the rows
    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic               outer;   // beyond outer radius: dim only
        logic               inner;   // inside inner radius: full light
    } side_t;

    typedef struct packed {
        logic [D2_W-1:0]   rad;      // radicand bits still to consume, MSB first
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        side_t             side;
    } sqrt_pkt_t;

    typedef struct packed {
        logic [DIV_W-1:0]  rem;
        logic [RAMP_W-1:0] quo;
        side_t             side;
    } div_pkt_t;

endpackage

// File: sv/plfs_sqrt_cell.sv
// ============================================================================
// plfs_sqrt_cell - one bit of the square root
// Takes two radicand bits, settles one root bit, registers the result.
// ============================================================================
module plfs_sqrt_cell
    import plfs_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  sqrt_pkt_t in_pkt,
    output logic      out_valid,
    input  logic      out_ready,
    output sqrt_pkt_t out_pkt
);

    logic      v_reg;
    sqrt_pkt_t pkt_reg;
    sqrt_pkt_t pkt_next;
    logic [REM_W-1:0] shifted;
    logic [REM_W-1:0] trial;

    always_comb begin
        shifted  = {in_pkt.rem[REM_W-3:0], in_pkt.rad[D2_W-1 -: 2]};
        trial    = {{(REM_W-ROOT_W-2){1'b0}}, in_pkt.root, 2'b01};
        pkt_next = in_pkt;
        pkt_next.rad = {in_pkt.rad[D2_W-3:0], 2'b00};
        if (shifted >= trial) begin
            pkt_next.rem  = shifted - trial;
            pkt_next.root = {in_pkt.root[ROOT_W-2:0], 1'b1};
        end else begin
            pkt_next.rem  = shifted;
            pkt_next.root = {in_pkt.root[ROOT_W-2:0], 1'b0};
        end
    end

    assign in_ready = !v_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (in_ready) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            pkt_reg <= pkt_next;
        end
    end

    assign out_valid = v_reg;
    assign out_pkt   = pkt_reg;

endmodule

// File: sv/plfs_div_cell.sv
// ============================================================================
// plfs_div_cell - one bit of the ramp quotient
// Compare-subtract against the span, shift, register.
// ============================================================================
module plfs_div_cell
    import plfs_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [RAD_W-1:0] span,
    input  logic             in_valid,
    output logic             in_ready,
    input  div_pkt_t         in_pkt,
    output logic             out_valid,
    input  logic             out_ready,
    output div_pkt_t         out_pkt
);

    logic     v_reg;
    div_pkt_t pkt_reg;
    div_pkt_t pkt_next;
    logic     qbit;
    logic [DIV_W-1:0] part;

    always_comb begin
        qbit     = (in_pkt.rem >= {1'b0, span});
        part     = qbit ? (in_pkt.rem - {1'b0, span}) : in_pkt.rem;
        pkt_next = in_pkt;
        pkt_next.rem = {part[DIV_W-2:0], 1'b0};
        pkt_next.quo = {in_pkt.quo[RAMP_W-2:0], qbit};
    end

    assign in_ready = !v_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (in_ready) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            pkt_reg <= pkt_next;
        end
    end

    assign out_valid = v_reg;
    assign out_pkt   = pkt_reg;

endmodule

// File: sv/point_light_falloff_shade.sv
// ============================================================================
// point_light_falloff_shade - 2D point light with linear falloff
// Dims or brightens the RGB bytes of an ARGB color by the distance of the
// item's position to a configured light; alpha passes unchanged.
// ============================================================================
//
//  channel | dir | payload
//  --------+-----+---------------------------------------------------------
//  s_      | in  | tdata[63:0] = pos_x[15:0], pos_y[31:16], base_color[63:32]
//  m_      | out | tdata[31:0] = lit_color
//  cfg_    | in  | cfg_index selects register, cfg_wdata[15:0] low bits used
//
//  One item per clock sustained while the output is not stalled. The stages,
//  in order: two front stages (difference, squares), the squared distance,
//  a row of root cells (one root bit each), a clamp stage, a row of divide
//  cells (one ramp bit each), strength, channel products, saturating add.
//  Every stage has its own valid and stalls only when it is full and the
//  next one is blocked, so bubbles close up behind a stalled output.
//  Reset (aresetn low, synchronous) empties all stages and restores the
//  register defaults; intensity comes up at 1.0.
//
module point_light_falloff_shade
    import plfs_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // config write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DAT_W-1:0]  cfg_wdata,
    // input items
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [63:0]           s_tdata,   // pos_x, pos_y, base_color
    // result items
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [COLOR_W-1:0]    m_tdata    // lit_color
);

    // row lengths are fixed by the root and ramp widths
    localparam int SQRT_STEPS = SQRT_STEPS_DEF;
    localparam int DIV_STEPS  = DIV_STEPS_DEF;

    // ---------------- configuration registers ----------------
    logic [COORD_W-1:0] light_x_reg, light_y_reg;
    logic [RAD_W-1:0]   fall_in_reg, fall_out_reg;
    logic [CHAN_W-1:0]  light_r_reg, light_g_reg, light_b_reg;
    logic [INT_W-1:0]   intensity_reg;
    // derived from config, refreshed every cycle
    logic [2*RAD_W-1:0] fo2_reg, fi2_reg;
    logic [INT_W-1:0]   k_reg;
    logic [RAD_W-1:0]   span_reg;
    logic               ramp_ok_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            light_x_reg   <= '0;
            light_y_reg   <= '0;
            fall_in_reg   <= '0;
            fall_out_reg  <= '0;
            light_r_reg   <= '0;
            light_g_reg   <= '0;
            light_b_reg   <= '0;
            intensity_reg <= UNITY;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_LIGHT_X:   light_x_reg   <= cfg_wdata;
                REG_LIGHT_Y:   light_y_reg   <= cfg_wdata;
                REG_FALL_IN:   fall_in_reg   <= cfg_wdata;
                REG_FALL_OUT:  fall_out_reg  <= cfg_wdata;
                REG_LIGHT_RED: light_r_reg   <= cfg_wdata[CHAN_W-1:0];
                REG_LIGHT_GRN: light_g_reg   <= cfg_wdata[CHAN_W-1:0];
                REG_LIGHT_BLU: light_b_reg   <= cfg_wdata[CHAN_W-1:0];
                REG_INTENSITY: intensity_reg <= cfg_wdata[INT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        fo2_reg     <= fall_out_reg * fall_out_reg;
        fi2_reg     <= fall_in_reg * fall_in_reg;
        k_reg       <= (intensity_reg > UNITY) ? UNITY : intensity_reg;
        span_reg    <= fall_out_reg - fall_in_reg;
        ramp_ok_reg <= (fall_out_reg > fall_in_reg);
    end

    // ---------------- stage 0: differences ----------------
    logic s0_v_reg, rdy0, rdy1, rdy2;
    logic signed [DIFF_W-1:0] dx_reg, dy_reg;
    logic [COLOR_W-1:0] col0_reg;

    assign rdy0     = !s0_v_reg || rdy1;
    assign s_tready = rdy0;

    always_ff @(posedge aclk) begin
        if (!aresetn) s0_v_reg <= 1'b0;
        else if (rdy0) s0_v_reg <= s_tvalid;
    end

    always_ff @(posedge aclk) begin
        if (rdy0 && s_tvalid) begin
            dx_reg   <= $signed({light_x_reg[COORD_W-1], light_x_reg})
                      - $signed({s_tdata[COORD_W-1], s_tdata[COORD_W-1:0]});
            dy_reg   <= $signed({light_y_reg[COORD_W-1], light_y_reg})
                      - $signed({s_tdata[2*COORD_W-1], s_tdata[2*COORD_W-1:COORD_W]});
            col0_reg <= s_tdata[63:32];
        end
    end

    // ---------------- stage 1: squares ----------------
    logic s1_v_reg;
    logic signed [SQ_W-1:0] sqx, sqy;
    logic [SQ_W-1:0] sqx_reg, sqy_reg;
    logic [COLOR_W-1:0] col1_reg;

    assign sqx  = dx_reg * dx_reg;
    assign sqy  = dy_reg * dy_reg;
    assign rdy1 = !s1_v_reg || rdy2;

    always_ff @(posedge aclk) begin
        if (!aresetn) s1_v_reg <= 1'b0;
        else if (rdy1) s1_v_reg <= s0_v_reg;
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && s0_v_reg) begin
            sqx_reg  <= sqx;
            sqy_reg  <= sqy;
            col1_reg <= col0_reg;
        end
    end

    // ---------------- stage 2: squared distance ----------------
    // both squares stay below 2^32, so the sum fits D2_W bits
    logic s2_v_reg;
    logic [D2_W-1:0] d2_reg;
    logic [COLOR_W-1:0] col2_reg;
    logic sq_in_ready;

    assign rdy2 = !s2_v_reg || sq_in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) s2_v_reg <= 1'b0;
        else if (rdy2) s2_v_reg <= s1_v_reg;
    end

    always_ff @(posedge aclk) begin
        if (rdy2 && s1_v_reg) begin
            d2_reg   <= sqx_reg + sqy_reg;
            col2_reg <= col1_reg;
        end
    end

    // ---------------- root cell row ----------------
    // zone tests are exact on the squared distance
    sqrt_pkt_t sq_pkt [SQRT_STEPS+1];
    logic      sq_v   [SQRT_STEPS+1];
    logic      sq_rdy [SQRT_STEPS+1];

    always_comb begin
        sq_pkt[0].rad        = d2_reg;
        sq_pkt[0].rem        = '0;
        sq_pkt[0].root       = '0;
        sq_pkt[0].side.color = col2_reg;
        sq_pkt[0].side.outer = (d2_reg > {{(D2_W-2*RAD_W){1'b0}}, fo2_reg});
        sq_pkt[0].side.inner = (d2_reg < {{(D2_W-2*RAD_W){1'b0}}, fi2_reg});
    end
    assign sq_v[0]     = s2_v_reg;
    assign sq_in_ready = sq_rdy[0];

    for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
        plfs_sqrt_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (sq_v[i]),
            .in_ready  (sq_rdy[i]),
            .in_pkt    (sq_pkt[i]),
            .out_valid (sq_v[i+1]),
            .out_ready (sq_rdy[i+1]),
            .out_pkt   (sq_pkt[i+1])
        );
    end

    // ---------------- clamp stage ----------------
    logic sc_v_reg, rdyc, dv_in_ready;
    logic [ROOT_W-1:0] ra_hi;
    logic [RAD_W-1:0]  ra_cl;
    div_pkt_t dv_first_reg;

    always_comb begin
        ra_hi = sq_pkt[SQRT_STEPS].root;
        if (ra_hi > {{(ROOT_W-RAD_W){1'b0}}, fall_out_reg})
            ra_cl = fall_out_reg;
        else
            ra_cl = ra_hi[RAD_W-1:0];
        if (ra_cl < fall_in_reg)
            ra_cl = fall_in_reg;
    end

    assign rdyc                = !sc_v_reg || dv_in_ready;
    assign sq_rdy[SQRT_STEPS]  = rdyc;

    always_ff @(posedge aclk) begin
        if (!aresetn) sc_v_reg <= 1'b0;
        else if (rdyc) sc_v_reg <= sq_v[SQRT_STEPS];
    end

    always_ff @(posedge aclk) begin
        if (rdyc && sq_v[SQRT_STEPS]) begin
            dv_first_reg.rem  <= {1'b0, fall_out_reg - ra_cl};
            dv_first_reg.quo  <= '0;
            dv_first_reg.side <= sq_pkt[SQRT_STEPS].side;
        end
    end

    // ---------------- divide cell row ----------------
    // numerator <= span, so DIV_STEPS quotient bits give the Q1.8 ramp
    div_pkt_t dv_pkt [DIV_STEPS+1];
    logic     dv_v   [DIV_STEPS+1];
    logic     dv_rdy [DIV_STEPS+1];

    assign dv_pkt[0]   = dv_first_reg;
    assign dv_v[0]     = sc_v_reg;
    assign dv_in_ready = dv_rdy[0];

    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
        plfs_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .span      (span_reg),
            .in_valid  (dv_v[j]),
            .in_ready  (dv_rdy[j]),
            .in_pkt    (dv_pkt[j]),
            .out_valid (dv_v[j+1]),
            .out_ready (dv_rdy[j+1]),
            .out_pkt   (dv_pkt[j+1])
        );
    end

    // ---------------- strength stage ----------------
    logic st_v_reg, rdyt, rdym, rdyo;
    logic [RAMP_W-1:0] ramp;
    logic [STR_W-1:0]  t_reg;
    side_t             side_t_reg;

    always_comb begin
        ramp = dv_pkt[DIV_STEPS].quo;
        if (!ramp_ok_reg || dv_pkt[DIV_STEPS].side.inner)
            ramp = UNITY;
    end

    assign rdyt              = !st_v_reg || rdym;
    assign dv_rdy[DIV_STEPS] = rdyt;

    always_ff @(posedge aclk) begin
        if (!aresetn) st_v_reg <= 1'b0;
        else if (rdyt) st_v_reg <= dv_v[DIV_STEPS];
    end

    always_ff @(posedge aclk) begin
        if (rdyt && dv_v[DIV_STEPS]) begin
            t_reg      <= k_reg * ramp;
            side_t_reg <= dv_pkt[DIV_STEPS].side;
        end
    end

    // ---------------- channel product stage ----------------
    // per lane: dimmed byte (c*k >> 8) or light addend (l*t >> 16)
    logic sm_v_reg;
    logic [CHAN_W:0]    add_r_reg, add_g_reg, add_b_reg;
    logic [COLOR_W-1:0] col_m_reg;
    logic               outer_m_reg;
    logic [2*CHAN_W-1:0]  dim_r, dim_g, dim_b;
    logic [CHAN_W+STR_W-1:0] lit_r, lit_g, lit_b;

    assign dim_r = (2*CHAN_W)'(side_t_reg.color[23:16] * k_reg);
    assign dim_g = (2*CHAN_W)'(side_t_reg.color[15:8]  * k_reg);
    assign dim_b = (2*CHAN_W)'(side_t_reg.color[7:0]   * k_reg);
    assign lit_r = light_r_reg * t_reg;
    assign lit_g = light_g_reg * t_reg;
    assign lit_b = light_b_reg * t_reg;

    assign rdym = !sm_v_reg || rdyo;

    always_ff @(posedge aclk) begin
        if (!aresetn) sm_v_reg <= 1'b0;
        else if (rdym) sm_v_reg <= st_v_reg;
    end

    always_ff @(posedge aclk) begin
        if (rdym && st_v_reg) begin
            col_m_reg   <= side_t_reg.color;
            outer_m_reg <= side_t_reg.outer;
            if (side_t_reg.outer) begin
                add_r_reg <= {1'b0, dim_r[2*CHAN_W-1:CHAN_W]};
                add_g_reg <= {1'b0, dim_g[2*CHAN_W-1:CHAN_W]};
                add_b_reg <= {1'b0, dim_b[2*CHAN_W-1:CHAN_W]};
            end else begin
                add_r_reg <= lit_r[CHAN_W+STR_W-1 -: CHAN_W+1];
                add_g_reg <= lit_g[CHAN_W+STR_W-1 -: CHAN_W+1];
                add_b_reg <= lit_b[CHAN_W+STR_W-1 -: CHAN_W+1];
            end
        end
    end

    // ---------------- saturating add, output register ----------------
    logic [CHAN_W+1:0]  sum_r, sum_g, sum_b;
    logic [CHAN_W-1:0]  out_r, out_g, out_b;
    logic               m_v_reg;
    logic [COLOR_W-1:0] m_data_reg;

    assign sum_r = {2'b00, col_m_reg[23:16]} + {1'b0, add_r_reg};
    assign sum_g = {2'b00, col_m_reg[15:8]}  + {1'b0, add_g_reg};
    assign sum_b = {2'b00, col_m_reg[7:0]}   + {1'b0, add_b_reg};

    always_comb begin
        if (outer_m_reg) begin
            out_r = add_r_reg[CHAN_W-1:0];
            out_g = add_g_reg[CHAN_W-1:0];
            out_b = add_b_reg[CHAN_W-1:0];
        end else begin
            out_r = (sum_r > {2'b00, CHAN_MAX}) ? CHAN_MAX : sum_r[CHAN_W-1:0];
            out_g = (sum_g > {2'b00, CHAN_MAX}) ? CHAN_MAX : sum_g[CHAN_W-1:0];
            out_b = (sum_b > {2'b00, CHAN_MAX}) ? CHAN_MAX : sum_b[CHAN_W-1:0];
        end
    end

    assign rdyo = !m_v_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) m_v_reg <= 1'b0;
        else if (rdyo) m_v_reg <= sm_v_reg;
    end

    always_ff @(posedge aclk) begin
        if (rdyo && sm_v_reg) begin
            m_data_reg <= {col_m_reg[31:24], out_r, out_g, out_b};
        end
    end

    assign m_tvalid = m_v_reg;
    assign m_tdata  = m_data_reg;

endmodule

// File: sv/plfs_checker.sv
// ============================================================================
// plfs_checker - port-level checks for point_light_falloff_shade
// Reset emptying, output handshake and the stall path back to the input.
// ============================================================================
module plfs_checker
    import plfs_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_tready,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [COLOR_W-1:0] m_tdata
);

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    a_ready_flows: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input blocked while output drains");

    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input blocked with output empty");

endmodule

bind point_light_falloff_shade plfs_checker u_plfs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
